[rtl/indexed_ordered_list_engine_top_assert.svh]
// assertion macros shared by the list engine modules
`ifndef INDEXED_ORDERED_LIST_ENGINE_TOP_ASSERT_SVH
`define INDEXED_ORDERED_LIST_ENGINE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define IOLE_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("iole assertion failed");

// next-cycle implication
`define IOLE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("iole assertion failed");

`else

`define IOLE_ASSERT_IMPL(name, clk, rst, ante, cons)

`define IOLE_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

[rtl/iole_pkg.sv]
`default_nettype none

package iole_pkg;

   localparam int DEF_CAPACITY  = 64;
   localparam int DEF_DATA_BITS = 32;
   localparam int VALUE_BITS    = 32;
   localparam int OP_BITS       = 3;
   localparam int STATUS_BITS   = 2;

   typedef enum logic [OP_BITS-1:0] {
      OP_PUSH,
      OP_POP,
      OP_SHIFT,
      OP_UNSHIFT,
      OP_GET,
      OP_SET,
      OP_INSERT,
      OP_DELETE
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK,
      ST_EMPTY,
      ST_RANGE,
      ST_FULL
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic check;
      logic step_rd;
      logic step_wr;
      logic finish;
      logic rsp_load;
   } iole_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic err;
      logic loop_done;
   } iole_sts_type;

endpackage

`default_nettype wire

[rtl/iole_if.sv]
`default_nettype none

interface iole_req_if #(
   parameter int POS_BITS = $clog2(iole_pkg::DEF_CAPACITY)
);
   import iole_pkg::*;

   logic                          valid;
   logic                          ready;
   op_type                        op;
   logic [POS_BITS-1:0]           position;
   logic signed [VALUE_BITS-1:0]  value;

   modport source (output valid, output op, output position, output value, input ready);
   modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface iole_rsp_if #(
   parameter int CNT_BITS = $clog2(iole_pkg::DEF_CAPACITY + 1)
);
   import iole_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [VALUE_BITS-1:0]  read_data;
   status_type                    status;
   logic [CNT_BITS-1:0]           entry_count;

   modport source (output valid, output read_data, output status, output entry_count,
                   input ready);
   modport sink   (input valid, input read_data, input status, input entry_count,
                   output ready);
endinterface

`default_nettype wire

[rtl/iole_ctrl.sv]
`default_nettype none

`include "indexed_ordered_list_engine_top_assert.svh"

module iole_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  iole_pkg::iole_sts_type sts,
   output iole_pkg::iole_cmd_type cmd
);
   import iole_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_MOVE,
      S_MOVE_WR,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.capture  = (state_ff == S_IDLE) && req_valid;
      cmd.check    = (state_ff == S_CHECK);
      cmd.step_rd  = (state_ff == S_MOVE) && !sts.loop_done;
      cmd.finish   = (state_ff == S_MOVE) && sts.loop_done;
      cmd.step_wr  = (state_ff == S_MOVE_WR);
      cmd.rsp_load = (state_ff == S_DONE) && slot_free;

      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = sts.err ? S_DONE : S_MOVE;
         end
         S_MOVE: begin
            state_in = sts.loop_done ? S_DONE : S_MOVE_WR;
         end
         S_MOVE_WR: begin
            state_in = S_MOVE;
         end
         S_DONE: begin
            // wait here until the result register is free
            if (slot_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `IOLE_ASSERT_NEXT(a_accept_to_check, clock, reset, req_valid && req_ready, state_ff == S_CHECK)
   `IOLE_ASSERT_IMPL(a_write_after_read, clock, reset, cmd.step_wr, $past(cmd.step_rd))
   `IOLE_ASSERT_IMPL(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_DONE))

endmodule

`default_nettype wire

[rtl/iole_datapath.sv]
`default_nettype none

`include "indexed_ordered_list_engine_top_assert.svh"

module iole_datapath #(
   parameter int CAPACITY  = iole_pkg::DEF_CAPACITY,
   parameter int DATA_BITS = iole_pkg::DEF_DATA_BITS,
   parameter int POS_BITS  = $clog2(CAPACITY),
   parameter int CNT_BITS  = $clog2(CAPACITY + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  iole_pkg::iole_cmd_type               cmd,
   output iole_pkg::iole_sts_type               sts,
   input  iole_pkg::op_type                     req_op,
   input  logic [POS_BITS-1:0]                  req_position,
   input  logic signed [iole_pkg::VALUE_BITS-1:0] req_value,
   output logic signed [iole_pkg::VALUE_BITS-1:0] rsp_read_data,
   output iole_pkg::status_type                 rsp_status,
   output logic [CNT_BITS-1:0]                  rsp_entry_count
);
   import iole_pkg::*;

   // entries are stored at most as wide as the value port; a wider DATA_BITS is clipped to it
   localparam int STORE_BITS = (DATA_BITS < VALUE_BITS) ? DATA_BITS : VALUE_BITS;

   typedef enum logic [1:0] {
      KIND_INSERT,
      KIND_DELETE,
      KIND_GET,
      KIND_SET
   } kind_type;

   logic [STORE_BITS-1:0]        mem [CAPACITY];
   logic [STORE_BITS-1:0]        rd_ff;

   op_type                       op_ff;
   logic [POS_BITS-1:0]          pos_ff;
   logic [STORE_BITS-1:0]        val_ff;
   logic [CNT_BITS-1:0]          count_ff;
   kind_type                     kind_ff;
   status_type                   status_ff;
   logic [CNT_BITS-1:0]          tgt_ff;
   logic [CNT_BITS-1:0]          idx_ff;
   logic [CNT_BITS-1:0]          idx_in;

   logic signed [VALUE_BITS-1:0] rsp_data_ff;
   status_type                   rsp_status_ff;
   logic [CNT_BITS-1:0]          rsp_count_ff;

   kind_type                     kind_dec;
   status_type                   st_dec;
   logic [CNT_BITS-1:0]          tgt_dec;
   logic [CNT_BITS-1:0]          pos_ext;
   logic                         full;
   logic                         empty;

   logic [CNT_BITS-1:0]          src_idx;
   logic                         mem_we;
   logic                         mem_re;
   logic [POS_BITS-1:0]          wr_addr;
   logic [POS_BITS-1:0]          rd_addr;
   logic [STORE_BITS-1:0]        wr_data;

   // request decode against the current count
   always_comb begin
      pos_ext  = CNT_BITS'(pos_ff);
      full     = (count_ff >= CNT_BITS'(CAPACITY));
      empty    = (count_ff == '0);
      kind_dec = KIND_GET;
      tgt_dec  = pos_ext;
      st_dec   = ST_OK;
      unique case (op_ff)
         OP_PUSH: begin
            kind_dec = KIND_INSERT;
            tgt_dec  = count_ff;
            st_dec   = full ? ST_FULL : ST_OK;
         end
         OP_POP: begin
            kind_dec = KIND_DELETE;
            tgt_dec  = count_ff - CNT_BITS'(1);
            st_dec   = empty ? ST_EMPTY : ST_OK;
         end
         OP_SHIFT: begin
            kind_dec = KIND_DELETE;
            tgt_dec  = '0;
            st_dec   = empty ? ST_EMPTY : ST_OK;
         end
         OP_UNSHIFT: begin
            kind_dec = KIND_INSERT;
            tgt_dec  = '0;
            st_dec   = full ? ST_FULL : ST_OK;
         end
         OP_GET: begin
            kind_dec = KIND_GET;
            st_dec   = (pos_ext >= count_ff) ? ST_RANGE : ST_OK;
         end
         OP_SET: begin
            kind_dec = KIND_SET;
            st_dec   = (pos_ext >= count_ff) ? ST_RANGE : ST_OK;
         end
         OP_INSERT: begin
            // range test takes priority over full
            kind_dec = KIND_INSERT;
            if (pos_ext > count_ff) begin
               st_dec = ST_RANGE;
            end else if (full) begin
               st_dec = ST_FULL;
            end else begin
               st_dec = ST_OK;
            end
         end
         OP_DELETE: begin
            kind_dec = KIND_DELETE;
            st_dec   = (pos_ext >= count_ff) ? ST_RANGE : ST_OK;
         end
         default: begin
            kind_dec = KIND_GET;
            st_dec   = ST_OK;
         end
      endcase
   end

   always_comb begin
      sts.err = (st_dec != ST_OK);
      case (kind_ff)
         KIND_INSERT: sts.loop_done = (idx_ff == tgt_ff);
         KIND_DELETE: sts.loop_done = ((idx_ff + CNT_BITS'(1)) == count_ff);
         default:     sts.loop_done = 1'b1;
      endcase
   end

   // insert walks down from the tail, delete walks up towards it
   always_comb begin
      if (kind_ff == KIND_INSERT) begin
         src_idx = idx_ff - CNT_BITS'(1);
      end else begin
         src_idx = idx_ff + CNT_BITS'(1);
      end

      if (cmd.check) begin
         idx_in = (kind_dec == KIND_INSERT) ? count_ff : tgt_dec;
      end else if (cmd.step_wr) begin
         idx_in = (kind_ff == KIND_INSERT) ? (idx_ff - CNT_BITS'(1))
                                           : (idx_ff + CNT_BITS'(1));
      end else begin
         idx_in = idx_ff;
      end

      mem_re  = cmd.step_rd || (cmd.finish && (kind_ff == KIND_GET));
      rd_addr = cmd.step_rd ? src_idx[POS_BITS-1:0] : tgt_ff[POS_BITS-1:0];

      mem_we  = cmd.step_wr || (cmd.finish && (kind_ff inside {KIND_INSERT, KIND_SET}));
      wr_addr = cmd.step_wr ? idx_ff[POS_BITS-1:0] : tgt_ff[POS_BITS-1:0];
      wr_data = cmd.step_wr ? rd_ff : val_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= wr_data;
      if (mem_re) rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_op;
         pos_ff <= req_position;
         val_ff <= req_value[STORE_BITS-1:0];
      end
      if (cmd.check) begin
         kind_ff   <= kind_dec;
         tgt_ff    <= tgt_dec;
         status_ff <= st_dec;
      end
      idx_ff <= idx_in;
      if (cmd.rsp_load) begin
         rsp_data_ff   <= ((kind_ff == KIND_GET) && (status_ff == ST_OK))
                          ? VALUE_BITS'($signed(rd_ff)) : '0;
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.finish) begin
         if (kind_ff == KIND_INSERT) begin
            count_ff <= count_ff + CNT_BITS'(1);
         end else if (kind_ff == KIND_DELETE) begin
            count_ff <= count_ff - CNT_BITS'(1);
         end
      end
   end

   assign rsp_read_data   = rsp_data_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

   `IOLE_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_BITS'(CAPACITY))
   `IOLE_ASSERT_NEXT(a_insert_grows, clock, reset,
                     cmd.finish && (kind_ff == KIND_INSERT),
                     count_ff == ($past(count_ff) + CNT_BITS'(1)))
   `IOLE_ASSERT_NEXT(a_delete_shrinks, clock, reset,
                     cmd.finish && (kind_ff == KIND_DELETE),
                     count_ff == ($past(count_ff) - CNT_BITS'(1)))

endmodule

`default_nettype wire

[rtl/indexed_ordered_list_engine_top.sv]
`default_nettype none

// channel   direction   handshake     payload
// req_if    in          valid/ready   op, position, value
// rsp_if    out         valid/ready   read_data, status, entry_count
//
// a rejected request goes straight from the check to the result; for insert,
// delete, shift and unshift each of the n entries moved (at most CAPACITY-1)
// costs one read and one write on the entry memory
// reset clears the count; the entry memory is not cleared
// the result register holds while rsp_if.ready is low, and a new request is
// still taken meanwhile, its result waiting until the register frees up

module indexed_ordered_list_engine_top #(
   parameter int CAPACITY  = iole_pkg::DEF_CAPACITY,
   parameter int DATA_BITS = iole_pkg::DEF_DATA_BITS
) (
   input  logic              clock,
   input  logic              reset,
   iole_req_if.sink          req_if,
   iole_rsp_if.source        rsp_if
);
   import iole_pkg::*;

   localparam int POS_BITS = $clog2(CAPACITY);
   localparam int CNT_BITS = $clog2(CAPACITY + 1);

   iole_cmd_type cmd;
   iole_sts_type sts;

   iole_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   iole_datapath #(
      .CAPACITY  (CAPACITY),
      .DATA_BITS (DATA_BITS),
      .POS_BITS  (POS_BITS),
      .CNT_BITS  (CNT_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_op          (req_if.op),
      .req_position    (req_if.position),
      .req_value       (req_if.value),
      .rsp_read_data   (rsp_if.read_data),
      .rsp_status      (rsp_if.status),
      .rsp_entry_count (rsp_if.entry_count)
   );

endmodule

`default_nettype wire
